FILE: rtl/core/fcdh_pkg.sv
// shared types and constants of the finger count debounce history block
`default_nettype none
package fcdh_pkg;

	localparam int FINGER_W      = 6;
	localparam int TIME_W        = 32;
	localparam int MIN_DUR_W     = 16;
	localparam int MAX_ST_W      = 6;
	localparam int CNT_W         = 6;
	localparam int OUT_LIMIT     = 32;
	localparam int DEFAULT_DEPTH = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUR    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STATES = 1'd1;

	localparam logic [MIN_DUR_W-1:0] RST_MIN_DUR    = 16'd500;
	localparam logic [MAX_ST_W-1:0]  RST_MAX_STATES = 6'd20;

	typedef struct packed {
		logic                hand_present;
		logic [FINGER_W-1:0] finger_count;
		logic [TIME_W-1:0]   now_ms;
	} in_item_t;

	typedef struct packed {
		logic                entry_valid;
		logic [FINGER_W-1:0] state_fingers;
		logic [TIME_W-1:0]   state_start_ms;
		logic [TIME_W-1:0]   state_duration_ms;
		logic [TIME_W-1:0]   state_stop_ms;
		logic                last_entry;
	} out_item_t;

	typedef struct packed {
		logic [FINGER_W-1:0] fingers;
		logic [TIME_W-1:0]   start_ms;
		logic [TIME_W-1:0]   duration_ms;
		logic [TIME_W-1:0]   stop_ms;
	} hist_entry_t;

	typedef struct packed {
		logic ld_in;
		logic upd;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic a_busy;
		logic last_issued;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/fcdh_ram.sv
// generic single write port ram with registered read
`default_nettype none
module fcdh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/fcdh_ctrl.sv
// controller state machine: accept, update, emit
`default_nettype none
module fcdh_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   hand_present,
	input  wire fcdh_pkg::dp_status_t   status,
	output      logic                   in_stall,
	output      fcdh_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_stall = !((state_q == ST_IDLE) && !status.a_busy);
	assign accept   = in_valid && !in_stall;

	assign cmd.ld_in = accept && hand_present;
	assign cmd.upd   = (state_q == ST_UPD);
	assign cmd.emit  = (state_q == ST_EMIT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.ld_in) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.last_issued) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/fcdh_datapath.sv
// datapath: config, run tracking, history ram, emit pipeline
`default_nettype none
module fcdh_datapath #(
	parameter int HISTORY_DEPTH = fcdh_pkg::DEFAULT_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fcdh_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [fcdh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire fcdh_pkg::in_item_t              in_data,
	input  wire logic                            out_stall,
	input  wire fcdh_pkg::ctrl_cmd_t             cmd,
	output      fcdh_pkg::dp_status_t            status,
	output      logic                            out_valid,
	output      fcdh_pkg::out_item_t             out_data
);

	localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
	localparam int CNT_W   = fcdh_pkg::CNT_W;
	localparam int SUM_W   = CNT_W + 1;
	localparam int TIME_W  = fcdh_pkg::TIME_W;
	localparam int LIM_CAP = (HISTORY_DEPTH < fcdh_pkg::OUT_LIMIT) ?
		HISTORY_DEPTH : fcdh_pkg::OUT_LIMIT;
	localparam logic [CNT_W-1:0]  LIM_CAP_V  = CNT_W'(LIM_CAP);
	localparam logic [SUM_W-1:0]  DEPTH_V    = SUM_W'(HISTORY_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(HISTORY_DEPTH - 1);

	// configuration
	logic [fcdh_pkg::MIN_DUR_W-1:0] min_dur_q;
	logic [fcdh_pkg::MAX_ST_W-1:0]  max_st_q;

	// run and list bookkeeping
	logic [fcdh_pkg::FINGER_W-1:0] prev_q;
	logic [TIME_W-1:0]             run_start_q;
	logic [SLOT_W-1:0]             oldest_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [fcdh_pkg::FINGER_W-1:0] fin_q;
	logic [TIME_W-1:0]             now_q;

	// emit pipeline
	logic [SLOT_W-1:0]   emit_slot_q;
	logic [CNT_W-1:0]    pos_q;
	logic                a_valid_q;
	logic                a_last_q;
	logic                a_fill_q;
	logic                out_valid_q;
	fcdh_pkg::out_item_t out_q;

	// ram
	fcdh_pkg::hist_entry_t rd;
	fcdh_pkg::hist_entry_t wdata;
	logic                  we;
	logic [SLOT_W-1:0]     waddr;
	logic                  re;
	logic [SLOT_W-1:0]     raddr;

	// update logic
	logic [SUM_W-1:0]  oldest_x;
	logic [SUM_W-1:0]  cnt_x;
	logic [SUM_W-1:0]  newest_sum;
	logic [SUM_W-1:0]  append_sum;
	logic [SLOT_W-1:0] newest_slot;
	logic [SLOT_W-1:0] append_slot;
	logic [SLOT_W-1:0] oldest_inc;
	logic              match;
	logic              same_prev;
	logic [TIME_W-1:0] base;
	logic [TIME_W-1:0] diff;
	logic              long_run;
	logic              append;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  lim;
	logic              drop;
	logic [CNT_W-1:0]  cnt_next;
	logic [SLOT_W-1:0] oldest_next;

	// emit logic
	logic             b_load;
	logic             a_free;
	logic             issue;
	logic [CNT_W-1:0] total;
	logic             is_last;
	logic [SLOT_W-1:0] emit_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dur_q <= fcdh_pkg::RST_MIN_DUR;
			max_st_q  <= fcdh_pkg::RST_MAX_STATES;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fcdh_pkg::CFG_MIN_DUR: begin
					min_dur_q <= cfg_data;
				end
				fcdh_pkg::CFG_MAX_STATES: begin
					max_st_q <= fcdh_pkg::MAX_ST_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// slot arithmetic, both operands below depth so one subtract wraps
	assign oldest_x   = SUM_W'(oldest_q);
	assign cnt_x      = SUM_W'(cnt_q);
	assign newest_sum = oldest_x + cnt_x - SUM_W'(1);
	assign append_sum = oldest_x + cnt_x;

	assign newest_slot = (cnt_q == '0) ? '0 :
		(newest_sum >= DEPTH_V) ? SLOT_W'(newest_sum - DEPTH_V) : SLOT_W'(newest_sum);
	assign append_slot = (append_sum >= DEPTH_V) ?
		SLOT_W'(append_sum - DEPTH_V) : SLOT_W'(append_sum);
	assign oldest_inc  = (oldest_q == LAST_SLOT) ? '0 : oldest_q + SLOT_W'(1);

	// decision on the newest stored state read in the accept cycle
	assign match     = (cnt_q != '0) && (rd.fingers == fin_q);
	assign same_prev = (fin_q == prev_q);
	assign base      = match ? rd.start_ms : run_start_q;
	assign diff      = now_q - base;
	assign long_run  = diff > TIME_W'(min_dur_q);
	assign append    = !match && same_prev && long_run;

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign lim     = (max_st_q > LIM_CAP_V) ? LIM_CAP_V : max_st_q;
	assign drop    = cnt_inc >= lim;

	always_comb begin
		cnt_next    = cnt_q;
		oldest_next = oldest_q;
		if (append) begin
			if (drop) begin
				oldest_next = oldest_inc;
			end else begin
				cnt_next = cnt_inc;
			end
		end
	end

	// extend and append write the same word, only the slot differs
	assign we                = cmd.upd && (match || append);
	assign waddr             = match ? newest_slot : append_slot;
	assign wdata.fingers     = fin_q;
	assign wdata.start_ms    = base;
	assign wdata.duration_ms = diff;
	assign wdata.stop_ms     = now_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			fin_q <= in_data.finger_count;
			now_q <= in_data.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			run_start_q <= '0;
			oldest_q    <= '0;
			cnt_q       <= '0;
		end else if (cmd.upd) begin
			prev_q   <= fin_q;
			oldest_q <= oldest_next;
			cnt_q    <= cnt_next;
			if (!match && !same_prev) begin
				run_start_q <= now_q;
			end
		end
	end

	// emit: ram read register is stage a, out_q is stage b
	assign b_load   = a_valid_q && (!out_valid_q || !out_stall);
	assign a_free   = !a_valid_q || b_load;
	assign issue    = cmd.emit && a_free;
	assign total    = (cnt_q == '0) ? CNT_W'(1) : cnt_q;
	assign is_last  = ({1'b0, pos_q} + SUM_W'(1)) == {1'b0, total};
	assign emit_inc = (emit_slot_q == LAST_SLOT) ? '0 : emit_slot_q + SLOT_W'(1);

	assign re    = cmd.ld_in || issue;
	assign raddr = cmd.ld_in ? newest_slot : emit_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_slot_q <= '0;
			pos_q       <= '0;
			a_valid_q   <= 1'b0;
			a_last_q    <= 1'b0;
			a_fill_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.upd) begin
				emit_slot_q <= oldest_next;
				pos_q       <= '0;
			end else if (issue) begin
				emit_slot_q <= emit_inc;
				pos_q       <= pos_q + CNT_W'(1);
			end
			if (issue) begin
				a_valid_q <= 1'b1;
				a_last_q  <= is_last;
				a_fill_q  <= (cnt_q == '0);
			end else if (b_load) begin
				a_valid_q <= 1'b0;
			end
			if (b_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b_load) begin
			out_q.entry_valid       <= !a_fill_q;
			out_q.state_fingers     <= a_fill_q ? '0 : rd.fingers;
			out_q.state_start_ms    <= a_fill_q ? '0 : rd.start_ms;
			out_q.state_duration_ms <= a_fill_q ? '0 : rd.duration_ms;
			out_q.state_stop_ms     <= a_fill_q ? '0 : rd.stop_ms;
			out_q.last_entry        <= a_last_q;
		end
	end

	fcdh_ram #(
		.WIDTH ($bits(fcdh_pkg::hist_entry_t)),
		.DEPTH (HISTORY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd)
	);

	assign status.a_busy      = a_valid_q;
	assign status.last_issued = issue && is_last;
	assign out_valid          = out_valid_q;
	assign out_data           = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/finger_count_debounce_history.sv
// top level of the finger count debounce history block
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | in        | in_valid / in_stall  | fcdh_pkg::in_item_t  (one frame)
//  out     | out       | out_valid / out_stall| fcdh_pkg::out_item_t (one stored state)
//  cfg     | in        | cfg_we             | cfg_idx, cfg_data (write only)
//
// a frame with a hand is accepted, then the history is updated, and then the stored
// states are emitted oldest first, each read in turn through the single read port
// of the history ram
// a frame with no hand is taken without a history update and yields no item
// reset clears the run tracking and empties the list; the ram itself is not cleared
// output stalls back up through a two-entry emit pipeline into the controller
`default_nettype none
module finger_count_debounce_history #(
	parameter int HISTORY_DEPTH = fcdh_pkg::DEFAULT_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [fcdh_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [fcdh_pkg::CFG_DATA_W-1:0] cfg_data,
	// frame items in
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire fcdh_pkg::in_item_t              in_data,
	// history items out, oldest first
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      fcdh_pkg::out_item_t             out_data
);

	// command and status between controller and datapath
	fcdh_pkg::ctrl_cmd_t  cmd;
	fcdh_pkg::dp_status_t status;

	// controller sequences accept, history update and emission
	fcdh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.hand_present (in_data.hand_present),
		.status       (status),
		.in_stall     (in_stall),
		.cmd          (cmd)
	);

	// datapath holds config, run timer, history ram and output register
	fcdh_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// the filler item for an empty list is always the only one of its run
	a_filler_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.entry_valid |-> out_data.last_entry)
		else $error("filler item without last_entry");

	// a frame with a hand blocks the input while the history is updated
	a_busy_after_hand: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.hand_present |=> in_stall)
		else $error("input taken during history update");

	// a frame with no hand leaves the block ready for the next one
	a_ready_after_no_hand: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !in_data.hand_present |=> !in_stall)
		else $error("stall after frame with no hand");

	// the last read of a run leaves the controller idle for the next frame
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		status.last_issued |=> !cmd.emit && !cmd.upd)
		else $error("emission continued past the last item");

endmodule
`default_nettype wire

FILE: test/tb_finger_count_debounce_history.sv
// testbench for the finger count debounce history block: directed table, then random frames
`timescale 1ns / 1ps
module tb_finger_count_debounce_history;
	import fcdh_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 9;
	localparam int HIST_DEPTH    = DEFAULT_DEPTH;
	// longest correct quiet stretch is the long receiver hold, plus a burst or two
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	// a frame with no hand gives no item to wait for; this covers its acceptance easily
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 40;

	// how a frame's expectation is formed
	localparam int PREDICTED  = -1;
	localparam int TYPED_NONE = 0;
	localparam int TYPED_ONE  = 1;

	// empty list: one item with nothing valid in it, flagged as the last
	localparam out_item_t EMPTY_LIST_ITEM = {1'b0, 6'd0, 32'd0, 32'd0, 32'd0, 1'b1};

	typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		in_item_t              frame;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		int                    typed;
		out_item_t             want;
	} plan_row_t;

	// dut connections, all inputs known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_MIN_DUR;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	// shadow copy of the block's registers and history
	logic [MIN_DUR_W-1:0]  sh_min_dur    = RST_MIN_DUR;
	logic [MAX_ST_W-1:0]   sh_max_states = RST_MAX_STATES;
	logic [FINGER_W-1:0]   sh_prev       = '0;
	logic [TIME_W-1:0]     sh_run_start  = '0;
	hist_entry_t           sh_hist [HIST_DEPTH];
	int unsigned           sh_oldest     = 0;
	int unsigned           sh_count      = 0;

	// history items still owed by the block, oldest first
	out_item_t pending_states [$];
	plan_row_t plan [$];

	int  n_fail      = 0;
	int  quiet_count = 0;
	bit  idle_on     = 1'b1;
	bit  hold_req    = 1'b0;
	bit  hold_taken  = 1'b0;
	int  hold_left   = 0;
	int  burst_left  = 0;

	finger_count_debounce_history u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ring position of the n-th oldest stored state
	function automatic int unsigned slot_at(input int unsigned pos);
		return (sh_oldest + pos) % HIST_DEPTH;
	endfunction

	// apply one frame to the shadow history and list the items it should produce
	task automatic advance_history(input in_item_t frame, output out_item_t outs [$]);
		int unsigned   s;
		int unsigned   lim;
		logic [31:0]   dur;
		out_item_t     o;
		outs = {};
		// no hand: nothing moves, nothing comes out
		if (!frame.hand_present)
			return;
		if (sh_count > 0 && sh_hist[slot_at(sh_count - 1)].fingers == frame.finger_count) begin
			// same count as the newest state: stretch it up to now
			s = slot_at(sh_count - 1);
			sh_hist[s].duration_ms = frame.now_ms - sh_hist[s].start_ms;
			sh_hist[s].stop_ms     = frame.now_ms;
		end else if (frame.finger_count == sh_prev) begin
			// count held since the run began; it must last strictly longer than the minimum
			dur = frame.now_ms - sh_run_start;
			if (dur > 32'(sh_min_dur)) begin
				s = slot_at(sh_count);
				sh_hist[s] = {frame.finger_count, sh_run_start, dur, frame.now_ms};
				sh_count++;
				// limit clamps to the ring size; zero acts like one
				lim = sh_max_states;
				if (lim > HIST_DEPTH)
					lim = HIST_DEPTH;
				if (lim > OUT_LIMIT)
					lim = OUT_LIMIT;
				// only one oldest state goes per append, even if the limit dropped a lot
				if (sh_count >= lim) begin
					sh_oldest = slot_at(1);
					sh_count--;
				end
			end
		end else begin
			// count changed: the run starts over
			sh_run_start = frame.now_ms;
		end
		sh_prev = frame.finger_count;
		if (sh_count == 0) begin
			outs.push_back(EMPTY_LIST_ITEM);
			return;
		end
		for (int unsigned i = 0; i < sh_count && i < OUT_LIMIT; i++) begin
			s = slot_at(i);
			o.entry_valid       = 1'b1;
			o.state_fingers     = sh_hist[s].fingers;
			o.state_start_ms    = sh_hist[s].start_ms;
			o.state_duration_ms = sh_hist[s].duration_ms;
			o.state_stop_ms     = sh_hist[s].stop_ms;
			o.last_entry        = (i + 1 == sh_count);
			outs.push_back(o);
		end
	endtask

	// offer one frame until taken; the expectation is queued just before the edge that takes it
	task automatic send_frame(input in_item_t frame, input int typed, input out_item_t want);
		out_item_t outs [$];
		bit        taken;
		// random sender gap before the item
		if (idle_on && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= frame;
		taken = 1'b0;
		while (!taken) begin
			// inputs only move at the rising edge, so stall is settled here
			@(negedge clk);
			taken = !in_stall;
			if (taken) begin
				advance_history(frame, outs);
				if (typed == PREDICTED)
					foreach (outs[k]) pending_states.push_back(outs[k]);
				else if (typed == TYPED_ONE)
					pending_states.push_back(want);
			end
			@(posedge clk);
		end
	endtask

	// register write, only once the block has gone quiet
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_states.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		if (idx == CFG_MIN_DUR)
			sh_min_dur = data[MIN_DUR_W-1:0];
		else if (idx == CFG_MAX_STATES)
			sh_max_states = data[MAX_ST_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(input int unsigned min_dur, input int unsigned max_st);
		write_cfg(CFG_MIN_DUR, CFG_DATA_W'(min_dur));
		write_cfg(CFG_MAX_STATES, CFG_DATA_W'(max_st));
	endtask

	task automatic add_frame(input logic hand, input logic [FINGER_W-1:0] fingers,
				input logic [TIME_W-1:0] now, input int typed, input out_item_t want);
		plan_row_t r;
		r.kind  = ROW_FRAME;
		r.frame = {hand, fingers, now};
		r.idx   = CFG_MIN_DUR;
		r.data  = '0;
		r.typed = typed;
		r.want  = want;
		plan.push_back(r);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r.kind  = ROW_CFG;
		r.frame = '0;
		r.idx   = idx;
		r.data  = data;
		r.typed = TYPED_NONE;
		r.want  = EMPTY_LIST_ITEM;
		plan.push_back(r);
	endtask

	// random frames: mostly runs of one count with time steps around the minimum,
	// so states get appended and stretched, with some noise mixed in
	task automatic run_phase(input int n_hand, input int noise_pct, input int hold_at);
		int              hand_cnt;
		int              reps;
		logic [5:0]      fingers;
		logic [31:0]     now;
		int unsigned     md;
		int unsigned     step;
		in_item_t        frame;
		hand_cnt = 0;
		now = $urandom;
		while (hand_cnt < n_hand) begin
			fingers = 6'($urandom_range(0, 63));
			reps = $urandom_range(1, 3);
			for (int r = 0; r < reps && hand_cnt < n_hand; r++) begin
				if ($urandom_range(0, 99) < noise_pct) begin
					// noise: any hand flag, any count, any time
					frame.hand_present = 1'($urandom_range(0, 1));
					frame.finger_count = 6'($urandom);
					frame.now_ms       = $urandom;
				end else begin
					md = sh_min_dur;
					if ($urandom_range(0, 3) != 0)
						step = $urandom_range(md + 1, 2 * md + 2);
					else
						step = $urandom_range(0, md);
					now += step;
					frame.hand_present = 1'b1;
					frame.finger_count = fingers;
					frame.now_ms       = now;
				end
				if (frame.hand_present)
					hand_cnt++;
				// long receiver hold once the list is long
				if (hand_cnt == hold_at)
					hold_req <= 1'b1;
				send_frame(frame, PREDICTED, EMPTY_LIST_ITEM);
			end
		end
	endtask

	// receiver: random stall bursts, one long hold on request
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			out_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			out_stall  <= 1'b1;
		end else if (idle_on && $urandom_range(0, 99) < 8) begin
			burst_left <= $urandom_range(0, 17);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker: outputs are settled mid-cycle, compare against the oldest expectation
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_states.size() == 0) begin
				$error("history item with nothing expected: %h", out_data);
				n_fail++;
			end else begin
				want = pending_states.pop_front();
				if (out_data.entry_valid !== want.entry_valid) begin
					$error("entry_valid expected %0h got %0h", want.entry_valid,
						out_data.entry_valid);
					n_fail++;
				end
				if (out_data.state_fingers !== want.state_fingers) begin
					$error("state_fingers expected %0d got %0d", want.state_fingers,
						out_data.state_fingers);
					n_fail++;
				end
				if (out_data.state_start_ms !== want.state_start_ms) begin
					$error("state_start_ms expected %0h got %0h", want.state_start_ms,
						out_data.state_start_ms);
					n_fail++;
				end
				if (out_data.state_duration_ms !== want.state_duration_ms) begin
					$error("state_duration_ms expected %0h got %0h", want.state_duration_ms,
						out_data.state_duration_ms);
					n_fail++;
				end
				if (out_data.state_stop_ms !== want.state_stop_ms) begin
					$error("state_stop_ms expected %0h got %0h", want.state_stop_ms,
						out_data.state_stop_ms);
					n_fail++;
				end
				if (out_data.last_entry !== want.last_entry) begin
					$error("last_entry expected %0h got %0h", want.last_entry,
						out_data.last_entry);
					n_fail++;
				end
			end
		end
	end

	// watchdog: too long without any item moving on either side
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_count = 0;
		else
			quiet_count++;
		if (quiet_count >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		foreach (sh_hist[k]) sh_hist[k] = '0;

		// directed part, default limits 500 / 20
		add_frame(1'b0, 6'd63, 32'hFFFF_FFFF, TYPED_NONE, EMPTY_LIST_ITEM);  // no hand
		add_frame(1'b1, 6'd0, 32'd0, TYPED_ONE, EMPTY_LIST_ITEM);           // empty list
		add_frame(1'b1, 6'd63, 32'd100, TYPED_ONE, EMPTY_LIST_ITEM);        // run restarts
		add_frame(1'b1, 6'd63, 32'd600, TYPED_ONE, EMPTY_LIST_ITEM);        // exactly the min
		add_frame(1'b1, 6'd63, 32'd601, TYPED_ONE,
			{1'b1, 6'd63, 32'd100, 32'd501, 32'd601, 1'b1});                // first state
		add_frame(1'b1, 6'd63, 32'd900, PREDICTED, EMPTY_LIST_ITEM);        // stretch newest
		add_frame(1'b0, 6'd5, 32'd1000, TYPED_NONE, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd5, 32'd1000, PREDICTED, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd5, 32'd1501, PREDICTED, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd63, 32'd2000, PREDICTED, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd63, 32'd2600, PREDICTED, EMPTY_LIST_ITEM);       // repeat of an older count
		add_frame(1'b1, 6'd42, 32'hFFFF_FF00, PREDICTED, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd42, 32'h0000_0100, PREDICTED, EMPTY_LIST_ITEM);  // time wraps
		add_frame(1'b1, 6'd42, 32'h0000_0300, PREDICTED, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd42, 32'h0000_0010, PREDICTED, EMPTY_LIST_ITEM);  // time goes back
		add_frame(1'b1, 6'd21, 32'h8000_0000, PREDICTED, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd21, 32'h7FFF_FFFF, PREDICTED, EMPTY_LIST_ITEM);  // duration all ones
		// limit lowered below the list length: one drop per append
		add_cfg(CFG_MAX_STATES, 16'd3);
		add_frame(1'b1, 6'd9, 32'd1000, PREDICTED, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd9, 32'd1600, PREDICTED, EMPTY_LIST_ITEM);
		// limit zero and no minimum
		add_cfg(CFG_MAX_STATES, 16'd0);
		add_cfg(CFG_MIN_DUR, 16'd0);
		add_frame(1'b1, 6'd1, 32'd5000, PREDICTED, EMPTY_LIST_ITEM);
		add_frame(1'b1, 6'd1, 32'd5000, PREDICTED, EMPTY_LIST_ITEM);        // zero is not enough
		add_frame(1'b1, 6'd1, 32'd5001, PREDICTED, EMPTY_LIST_ITEM);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CFG)
				write_cfg(plan[k].idx, plan[k].data);
			else
				send_frame(plan[k].frame, plan[k].typed, plan[k].want);
		end

		// random part; each limit change waits for the block to drain
		set_limits(0, 32);        // list can grow to one short of its full size
		run_phase(80, 10, 70);
		set_limits(65535, 63);    // limit past the ring size
		run_phase(20, 15, -1);
		set_limits(7, 1);         // nothing can stay in the list
		run_phase(15, 15, -1);
		set_limits(300, 0);
		run_phase(12, 20, -1);
		set_limits(1000, 5);
		run_phase(25, 15, -1);
		set_limits(500, 20);
		idle_on <= 1'b0;          // closing stretch runs at full rate
		run_phase(25, 10, -1);

		in_valid <= 1'b0;
		while (pending_states.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_fail == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
